// ===== sv/ssl_pkg.sv =====
package ssl_pkg;

  localparam int NOTE_SLOTS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_BITS   = $clog2(NOTE_SLOTS);
  localparam int COUNT_BITS  = 5;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_WRITE    = 2'd1;
  localparam logic [1:0] CMD_SET_STEP = 2'd2;
  localparam logic [1:0] CMD_SPARE    = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_COUNT     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEGATO_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANDOM_CHANCE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANDOM_LOW     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANDOM_HIGH    = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SLOT_BITS-1:0] slot_t;

endpackage

// ===== sv/ssl_in_if.sv =====
interface ssl_in_if import ssl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        clock_high;
  logic [15:0] draw_chance;
  logic [15:0] draw_value;
  slot_t       slot;
  sample_t     note_value;

  modport source (output valid, cmd, clock_high, draw_chance, draw_value, slot, note_value,
                  input ready);
  modport sink (input valid, cmd, clock_high, draw_chance, draw_value, slot, note_value,
                output ready);
endinterface

// ===== sv/ssl_out_if.sv =====
interface ssl_out_if import ssl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  slot_t   step_now;
  logic    gliding;

  modport source (output valid, sample_out, step_now, gliding, input ready);
  modport sink (input valid, sample_out, step_now, gliding, output ready);
endinterface

// ===== sv/ssl_ram.sv =====
module ssl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/step_sequencer_legato.sv =====
// Step sequencer with glide. Input beats are note writes, step sets and sample ticks; only a
// sample tick returns an output beat. Writes, step sets and unused commands finish in idle. A
// sample tick runs through RD0, RD1, RD2 and DONE until its result is loaded into the output
// register, with RMUL and RWR first if the random replacement fires, and GMUL, DIVINIT and DIV
// before DONE while the output glides; the glide quotient comes from a shared 17x17 multiplier
// and a radix-2 divider retiring one quotient bit per cycle for 32 bits. The note table is a
// RAM with one read and one write port, read twice per tick (previous and current note). The
// next input beat is taken while a finished result still waits in the output register.
module step_sequencer_legato import ssl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  ssl_in_if.sink                  in_ch,
  ssl_out_if.source               out_ch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RMUL    = 4'd1;
  localparam logic [3:0] S_RWR     = 4'd2;
  localparam logic [3:0] S_RD0     = 4'd3;
  localparam logic [3:0] S_RD1     = 4'd4;
  localparam logic [3:0] S_RD2     = 4'd5;
  localparam logic [3:0] S_GMUL    = 4'd6;
  localparam logic [3:0] S_DIVINIT = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state;

  logic [COUNT_BITS-1:0] step_count;
  logic [15:0]           legato_samples;
  logic [15:0]           random_chance;
  sample_t               random_low;
  sample_t               random_high;

  slot_t       current_step;
  logic        clock_level_seen;
  logic [15:0] since_edge;
  logic [NOTE_SLOTS-1:0] slot_valid;

  logic [15:0] draw_value_q;
  logic        rand_q;
  logic        glide_q;
  sample_t     prev_q;
  sample_t     cur_q;
  logic        rd_ok;

  logic signed [33:0] prod;
  logic               neg;
  logic [31:0]        num;
  logic [15:0]        rem;
  logic [DIV_CNT_BITS-1:0] cnt;

  logic       out_valid;
  sample_t    out_sample;
  slot_t      out_step;
  logic       out_glide;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] step_plus;
  logic [COUNT_BITS-1:0] step_adv;
  logic [COUNT_BITS-1:0] step_fix;
  logic [15:0] since_inc;
  logic [15:0] since_new;
  logic        edge_seen;
  logic        rising;
  logic        glide_new;
  logic        rand_new;
  slot_t       prev_idx;
  logic        accept;

  sample_t            sub_x;
  sample_t            sub_y;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] rnd_adj;
  sample_t            rnd_note;
  logic signed [33:0] prod_abs;
  logic [16:0]        rem_sh;
  logic [16:0]        delta;
  sample_t            result;
  logic               load_out;

  logic        ram_we;
  slot_t       ram_waddr;
  sample_t     ram_wdata;
  slot_t       ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  sample_t     rd_note;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    if (step_count == '0) begin
      count = COUNT_BITS'(1);
    end else if (step_count > COUNT_BITS'(NOTE_SLOTS)) begin
      count = COUNT_BITS'(NOTE_SLOTS);
    end else begin
      count = step_count;
    end
  end

  always_comb begin
    since_inc = (since_edge != 16'hFFFF) ? since_edge + 16'd1 : since_edge;
    edge_seen = (in_ch.clock_high != clock_level_seen);
    rising    = edge_seen && in_ch.clock_high;
    step_plus = COUNT_BITS'(current_step) + COUNT_BITS'(1);
    if (rising) begin
      step_adv = (step_plus >= count) ? '0 : step_plus;
    end else begin
      step_adv = COUNT_BITS'(current_step);
    end
    step_fix  = (step_adv >= count) ? '0 : step_adv;
    since_new = edge_seen ? 16'd0 : since_inc;
    glide_new = in_ch.clock_high && (since_new < legato_samples);
    rand_new  = rising && (in_ch.draw_chance < random_chance);
    prev_idx  = (current_step == '0) ? SLOT_BITS'(count - COUNT_BITS'(1))
                                     : current_step - SLOT_BITS'(1);
  end

  // Shared subtract and multiply unit.
  always_comb begin
    if (state == S_RMUL) begin
      sub_x = random_high;
      sub_y = random_low;
      mul_b = {1'b0, draw_value_q};
    end else begin
      sub_x = cur_q;
      sub_y = prev_q;
      mul_b = {1'b0, since_edge};
    end
    mul_a = 17'(sub_x) - 17'(sub_y);
  end

  always_comb begin
    rnd_adj  = prod + (prod[33] ? 34'sd65535 : 34'sd0);
    rnd_note = random_low + sample_t'(rnd_adj[31:16]);
    prod_abs = prod[33] ? -prod : prod;
    rem_sh   = {rem, num[31]};
    delta    = neg ? -{1'b0, num[15:0]} : {1'b0, num[15:0]};
    result   = glide_q ? prev_q + sample_t'(delta[15:0]) : cur_q;
    rd_note  = rd_ok ? sample_t'(ram_rdata) : '0;
    load_out = (state == S_DONE) && (!out_valid || out_ch.ready);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_ch.slot;
    ram_wdata = in_ch.note_value;
    if (accept && in_ch.cmd == CMD_WRITE) begin
      ram_we = 1'b1;
    end else if (state == S_RWR) begin
      ram_we    = 1'b1;
      ram_waddr = current_step;
      ram_wdata = rnd_note;
    end
    ram_raddr = (state == S_RD0) ? prev_idx : current_step;
  end

  ssl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NOTE_SLOTS)) u_notes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count     <= COUNT_BITS'(NOTE_SLOTS);
      legato_samples <= '0;
      random_chance  <= '0;
      random_low     <= '0;
      random_high    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_COUNT:     step_count     <= cfg_data[COUNT_BITS-1:0];
        REG_LEGATO_SAMPLES: legato_samples <= cfg_data[15:0];
        REG_RANDOM_CHANCE:  random_chance  <= cfg_data[15:0];
        REG_RANDOM_LOW:     random_low     <= sample_t'(cfg_data);
        REG_RANDOM_HIGH:    random_high    <= sample_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      current_step     <= '0;
      clock_level_seen <= 1'b0;
      since_edge       <= '0;
      slot_valid       <= '0;
      rd_ok            <= 1'b0;
    end else begin
      rd_ok <= slot_valid[ram_raddr];
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.cmd)
              CMD_SET_STEP: current_step <= in_ch.slot;
              CMD_TICK: begin
                current_step     <= SLOT_BITS'(step_fix);
                since_edge       <= since_new;
                clock_level_seen <= in_ch.clock_high;
                state            <= rand_new ? S_RMUL : S_RD0;
              end
              default: ;
            endcase
          end
        end
        S_RMUL:    state <= S_RWR;
        S_RWR:     state <= S_RD0;
        S_RD0:     state <= S_RD1;
        S_RD1:     state <= S_RD2;
        S_RD2:     state <= glide_q ? S_GMUL : S_DONE;
        S_GMUL:    state <= S_DIVINIT;
        S_DIVINIT: state <= S_DIV;
        S_DIV: begin
          if (cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      draw_value_q <= in_ch.draw_value;
      rand_q       <= rand_new;
      glide_q      <= glide_new;
    end
    if (state == S_RD1) begin
      prev_q <= rd_note;
    end
    if (state == S_RD2) begin
      cur_q <= rd_note;
    end
    if (state == S_RMUL || state == S_GMUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_DIVINIT) begin
      neg <= prod[33];
      num <= prod_abs[31:0];
      rem <= '0;
      cnt <= '0;
    end
    if (state == S_DIV) begin
      cnt <= cnt + DIV_CNT_BITS'(1);
      if (rem_sh >= {1'b0, legato_samples}) begin
        rem <= 16'(rem_sh - {1'b0, legato_samples});
        num <= {num[30:0], 1'b1};
      end else begin
        rem <= rem_sh[15:0];
        num <= {num[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= result;
      out_step   <= current_step;
      out_glide  <= glide_q;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.step_now   = out_step;
  assign out_ch.gliding    = out_glide;

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (COUNT_BITS'(current_step) < count))
    else $error("step index not below active step count at result");

  a_rand_after_edge: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMUL) |-> (since_edge == 16'd0) && rand_q)
    else $error("random replacement started without a fresh clock edge");

  a_div_only_glide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> glide_q && (legato_samples != 16'd0))
    else $error("divider running without an active glide");
`endif

endmodule
